>>> src/assert_macros.svh
// Assertion macros used by the unit's RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LASU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lasu assertion failed");

// Condition that must hold in the cycle after a trigger.
`define LASU_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("lasu assertion failed");

`endif

>>> src/lasu_pkg.sv
// Package with constants and types of the longest arithmetic subsequence unit.
`timescale 1ns / 1ps
`default_nettype none

package lasu_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int MAX_VALUE    = 511;
  localparam int VALUES       = MAX_VALUE + 1;
  localparam int VAL_W        = 9;
  localparam int IDX_W        = 8;
  localparam int CNT_W        = 9;
  localparam int DIFF_W       = 10;
  localparam int STEP_W       = 8;
  localparam int RUN_AW       = IDX_W + DIFF_W;
  localparam int RUN_DEPTH    = 2 ** RUN_AW;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRO_F,
    ST_PRO_E,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

>>> src/longest_arithmetic_subsequence_unit.sv
// Streaming longest arithmetic subsequence unit built around three memories.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------
//   input   | in_valid / in_stall  | value, last
//   output  | out_valid / out_stall| length, truncated
//
// Each element of a sequence is stored and its first-occurrence entry checked,
// then one run table read and write is issued per earlier element and the read
// pipeline is drained; the first element skips the run and drain steps. A dropped
// element only marks the result as truncated. Ending a sequence adds a state that
// loads the result. After reset a clearing pass over the 512-entry first-occurrence
// table holds in_stall high while it runs. A stalled result sits in the output
// register while the next sequence is accepted; only ending a further sequence waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module longest_arithmetic_subsequence_unit import lasu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [VAL_W-1:0] value,
  input  logic             last,
  input  logic             in_valid,
  output logic             in_stall,
  output logic [CNT_W-1:0] length,
  output logic             truncated,
  output logic             out_valid,
  input  logic             out_stall
);

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  step_t            best;
  logic             ovf;
  idx_t             jreg;
  val_t             vreg;
  logic             lreg;
  idx_t             iss;
  val_t             clr_idx;
  idx_t             pro_f;

  val_t  estore    [MAX_ELEMENTS];
  idx_t  first_mem [VALUES];
  step_t runs      [RUN_DEPTH];

  val_t  est_rd_a;
  val_t  est_rd_b;
  idx_t  first_rd;
  step_t runs_rd;

  logic              p1_valid;
  idx_t              p1_i;
  logic [VAL_W+1:0]  p1_xw;
  logic              p1_xok;
  val_t              p1_x;
  logic [DIFF_W-1:0] p1_di;

  logic              p2_valid;
  idx_t              p2_i;
  logic [DIFF_W-1:0] p2_di;
  val_t              p2_x;
  logic              p2_xok;

  logic              p3_valid;
  logic              p3_lt;
  step_t             p3_r;
  logic [DIFF_W-1:0] p3_di;
  val_t              p3_x;
  logic              p3_xok;
  logic              p3_hit;
  step_t             steps;

  logic accept;
  logic full;
  logic issue;
  logic fin_load;
  logic first_we;
  val_t first_waddr;
  idx_t first_wdata;
  val_t first_raddr;

  assign full     = (count == CNT_W'(MAX_ELEMENTS));
  assign fin_load = (state == ST_FIN) && (!out_valid || !out_stall);

  assign p1_xw  = {1'b0, est_rd_a, 1'b0} - {2'b00, vreg};
  assign p1_xok = !p1_xw[VAL_W+1] && !p1_xw[VAL_W];
  assign p1_x   = p1_xw[VAL_W-1:0];
  assign p1_di  = {1'b0, vreg} + DIFF_W'(MAX_VALUE) - {1'b0, est_rd_a};

  assign first_raddr = (state == ST_IDLE) ? value : p1_x;

  assign p3_hit = p3_xok && p3_lt && (est_rd_b == p3_x);
  assign steps  = p3_hit ? (p3_r + STEP_W'(1)) : STEP_W'(1);

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    accept      = 1'b0;
    issue       = 1'b0;
    first_we    = 1'b0;
    first_waddr = vreg;
    first_wdata = jreg;
    unique case (state)
      ST_CLEAR: begin
        first_we    = 1'b1;
        first_waddr = clr_idx;
        first_wdata = '0;
        if (clr_idx == VAL_W'(MAX_VALUE)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept = 1'b1;
          if (full) state_next = last ? ST_FIN : ST_IDLE;
          else      state_next = ST_PRO_F;
        end
      end
      ST_PRO_F: begin
        state_next = ST_PRO_E;
      end
      ST_PRO_E: begin
        if (!((pro_f < jreg) && (est_rd_b == vreg))) first_we = 1'b1;
        if (jreg == '0) state_next = lreg ? ST_FIN : ST_IDLE;
        else            state_next = ST_RUN;
      end
      ST_RUN: begin
        issue = 1'b1;
        if (iss == jreg - IDX_W'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_valid && !p2_valid && !p3_valid) state_next = lreg ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      best      <= '0;
      ovf       <= 1'b0;
      iss       <= '0;
      out_valid <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      if (state == ST_CLEAR) clr_idx <= clr_idx + VAL_W'(1);
      if (accept) begin
        if (full) ovf <= 1'b1;
        else      count <= count + CNT_W'(1);
      end
      if (state == ST_PRO_E) iss <= '0;
      else if (issue)        iss <= iss + IDX_W'(1);
      if (p3_valid && (steps > best)) best <= steps;
      if (fin_load) begin
        out_valid <= 1'b1;
        count     <= '0;
        best      <= '0;
        ovf       <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vreg <= value;
      lreg <= last;
      jreg <= count[IDX_W-1:0];
    end
    if (state == ST_PRO_F) pro_f <= first_rd;
    p1_i   <= iss;
    p2_i   <= p1_i;
    p2_di  <= p1_di;
    p2_x   <= p1_x;
    p2_xok <= p1_xok;
    p3_lt  <= (first_rd < p2_i);
    p3_r   <= runs_rd;
    p3_di  <= p2_di;
    p3_x   <= p2_x;
    p3_xok <= p2_xok;
    if (fin_load) begin
      length    <= (count < CNT_W'(2)) ? count : (CNT_W'(best) + CNT_W'(1));
      truncated <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full) estore[count[IDX_W-1:0]] <= value;
    est_rd_a <= estore[iss];
    est_rd_b <= estore[first_rd];
  end

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_waddr] <= first_wdata;
    first_rd <= first_mem[first_raddr];
  end

  always_ff @(posedge clk) begin
    if (p3_valid) runs[{jreg, p3_di}] <= steps;
    runs_rd <= runs[{p1_i, p1_di}];
  end

  `LASU_ASSERT(a_count_cap, clk, rst, count <= CNT_W'(MAX_ELEMENTS))
  `LASU_ASSERT(a_pipe_busy, clk, rst, !p3_valid || state == ST_RUN || state == ST_DRAIN)
  `LASU_ASSERT(a_iss_range, clk, rst, state != ST_RUN || iss < jreg)
  `LASU_ASSERT_NEXT(a_fin_load, clk, rst, fin_load, out_valid && count == '0 && !ovf)

endmodule

`default_nettype wire

>>> tb/tb_longest_arithmetic_subsequence_unit.sv
// Testbench for the longest arithmetic subsequence unit: predicts each sequence result and checks it.
`timescale 1ns / 1ps

module tb_longest_arithmetic_subsequence_unit;
  import lasu_pkg::*;

  localparam int DIFF_SPAN       = 2 * MAX_VALUE + 1;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int TARGET_REQUESTS = 1350;
  localparam int LONG_ARITH_SEQ  = 12;
  localparam int LONG_DROP_SEQ   = 40;

  typedef struct {
    logic [CNT_W-1:0] length;
    logic             truncated;
  } summary_t;

  typedef val_t val_q_t[$];

  typedef enum {SEQ_ARITH, SEQ_ALPHABET, SEQ_EXTREME, SEQ_NOISE} seq_kind_t;

  logic             clk;
  logic             rst;
  val_t             value;
  logic             last;
  logic             in_valid;
  logic             in_stall;
  logic [CNT_W-1:0] length;
  logic             truncated;
  logic             out_valid;
  logic             out_stall;

  bit quiet;
  int idle_cycles;

  class subsequence_tracker;
    val_t             elems[MAX_ELEMENTS];
    bit [CNT_W-1:0]   step_count[MAX_ELEMENTS][DIFF_SPAN];
    int               stored;
    int               best_steps;
    bit               dropped;
    summary_t         pending_lengths[$];
    int               requests;
    int               sequences;
    int               checked;
    int               mismatches;
    int               longest;
    int               truncated_seqs;

    function void note_request(val_t v, bit is_last);
      int       i;
      int       d;
      int       di;
      int       steps;
      summary_t s;
      requests++;
      if (stored < MAX_ELEMENTS) begin
        for (d = 0; d < DIFF_SPAN; d++) step_count[stored][d] = '0;
        elems[stored] = v;
        for (i = 0; i < stored; i++) begin
          di = int'(v) + MAX_VALUE - int'(elems[i]);
          steps = int'(step_count[i][di]) + 1;
          if (steps > int'(step_count[stored][di])) step_count[stored][di] = CNT_W'(steps);
          if (steps > best_steps) best_steps = steps;
        end
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        s.length = (stored < 2) ? CNT_W'(stored) : CNT_W'(best_steps + 1);
        s.truncated = dropped;
        pending_lengths.push_back(s);
        sequences++;
        if (int'(s.length) > longest) longest = s.length;
        if (dropped) truncated_seqs++;
        stored = 0;
        best_steps = 0;
        dropped = 1'b0;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [CNT_W-1:0] got_len, logic got_trunc);
      summary_t want;
      if (pending_lengths.size() == 0) begin
        report($sformatf("result with nothing pending: length %0d truncated %0b",
                         got_len, got_trunc));
        return;
      end
      want = pending_lengths.pop_front();
      checked++;
      if (got_len !== want.length)
        report($sformatf("length expected %0d got %0d", want.length, got_len));
      if (got_trunc !== want.truncated)
        report($sformatf("truncated expected %0b got %0b", want.truncated, got_trunc));
    endfunction

    function int pending();
      return pending_lengths.size();
    endfunction
  endclass

  subsequence_tracker sb;

  longest_arithmetic_subsequence_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .last     (last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .length   (length),
    .truncated(truncated),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic val_q_t make_sequence(int n);
    val_q_t    q;
    seq_kind_t kind;
    val_t      alphabet[4];
    int        r;
    int        start;
    int        step;
    int        k;
    int        v;
    r = $urandom_range(0, 9);
    kind = (r < 5) ? SEQ_ARITH : (r < 7) ? SEQ_ALPHABET : (r < 8) ? SEQ_EXTREME : SEQ_NOISE;
    start = $urandom_range(0, MAX_VALUE);
    step = int'($urandom_range(0, 80)) - 40;
    foreach (alphabet[a]) alphabet[a] = val_t'($urandom);
    for (k = 0; k < n; k++) begin
      case (kind)
        SEQ_ARITH: begin
          v = start + step * k;
          if (v < 0 || v > MAX_VALUE || $urandom_range(0, 4) == 0)
            v = $urandom_range(0, MAX_VALUE);
        end
        SEQ_ALPHABET: v = alphabet[$urandom_range(0, 3)];
        SEQ_EXTREME: begin
          r = $urandom_range(0, 2);
          v = (r == 0) ? 0 : (r == 1) ? MAX_VALUE : $urandom_range(0, MAX_VALUE);
        end
        default: v = $urandom_range(0, MAX_VALUE);
      endcase
      q.push_back(val_t'(v));
    end
    return q;
  endfunction

  task automatic send_request(input val_t v, input bit is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      value <= val_t'($urandom);
      last <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    value <= v;
    last <= is_last;
    do @(posedge clk); while (in_stall);
    sb.note_request(v, is_last);
  endtask

  task automatic send_sequence(input val_q_t vals);
    int i;
    for (i = 0; i < vals.size(); i++) send_request(vals[i], i == vals.size() - 1);
  endtask

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(length, truncated);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("longest_arithmetic_subsequence_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    val_q_t q;
    int     seq_no;
    int     k;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    last = 1'b0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    q = '{9'd0};                                   send_sequence(q);
    q = '{9'd511};                                 send_sequence(q);
    q = '{9'd0, 9'd511};                           send_sequence(q);
    q = '{9'd511, 9'd0};                           send_sequence(q);
    q = '{9'd7, 9'd7, 9'd7, 9'd7};                 send_sequence(q);
    q = '{9'd1, 9'd3, 9'd5, 9'd2, 9'd7, 9'd9};     send_sequence(q);
    q = '{9'd10, 9'd20, 9'd5, 9'd30, 9'd0};        send_sequence(q);

    seq_no = 0;
    while (sb.requests < TARGET_REQUESTS) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (seq_no == LONG_ARITH_SEQ) begin
        q.delete();
        for (k = 0; k < MAX_ELEMENTS; k++) q.push_back(val_t'(2 * k));
      end else if (seq_no == LONG_DROP_SEQ) begin
        q = make_sequence(MAX_ELEMENTS + 3);
      end else if ($urandom_range(0, 4) == 0) begin
        q = make_sequence($urandom_range(17, 48));
      end else begin
        q = make_sequence($urandom_range(1, 16));
      end
      send_sequence(q);
      seq_no++;
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests in %0d sequences, %0d results checked",
             sb.requests, sb.sequences, sb.checked);
    $display("Longest run seen %0d, %0d sequences over capacity, %0d mismatches",
             sb.longest, sb.truncated_seqs, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("longest_arithmetic_subsequence_unit test passed");
    end else begin
      $display("longest_arithmetic_subsequence_unit test failed");
    end
    $finish;
  end

endmodule

>>> longest_arithmetic_subsequence_unit.f
+incdir+src
src/lasu_pkg.sv
src/longest_arithmetic_subsequence_unit.sv
tb/tb_longest_arithmetic_subsequence_unit.sv
